// ===== rtl/assert_macros.svh =====
// assertion helpers for the bound checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is low
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, switched off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/slir_pkg.sv =====
package slir_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/slir_store.sv =====
module slir_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [31:0]  i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic signed [31:0]  o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sorted_list_insert_remove_unit.sv =====
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------------
// command   | start / busy       | i_command, i_value
// result    | o_valid strobe     | o_status, o_count, o_smallest, o_smallest_valid
//
// one result per command; insert when full and remove when empty answer in the next cycle.
// otherwise the single read port of the entry store sets the pace: the scan reads and
// compares each entry examined, the shift reads and writes each entry moved, then an
// inserted value is placed and the result beat is raised.
// synchronous active-low reset empties the store; no clearing pass is needed.
// the receiver cannot stall: each result is on the ports for exactly one cycle.
module sorted_list_insert_remove_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [4:0]         o_count,
    output logic signed [31:0] o_smallest,
    output logic               o_smallest_valid
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRD   = 6'b000010,
        S_SCMP  = 6'b000100,
        S_MRD   = 6'b001000,
        S_MWR   = 6'b010000,
        S_PLACE = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic               r_cmd, n_cmd;
    logic signed [31:0] r_value, n_value;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_k, n_k;
    logic signed [31:0] r_smallest, n_smallest;
    logic               r_valid, n_valid;
    logic [1:0]         r_status, n_status;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;
    logic [AW-1:0]      w_raddr;
    logic signed [31:0] w_rdata;
    logic               w_lt;
    logic               w_eq;
    logic               w_last;
    logic [AW-1:0]      w_k_inc;
    logic [AW-1:0]      w_k_dec;
    logic [CW+4:0]      w_count_ext;

    slir_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // the comparisons of the read entry against the held value
    assign w_lt    = w_rdata < r_value;
    assign w_eq    = w_rdata == r_value;
    assign w_last  = CW'(r_idx) == (r_count - CW'(1));
    assign w_k_inc = r_k + AW'(1);
    assign w_k_dec = r_k - AW'(1);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_k        = r_k;
        n_smallest = r_smallest;
        n_valid    = 1'b0;
        n_status   = r_status;
        w_we       = 1'b0;
        w_waddr    = r_k;
        w_wdata    = w_rdata;
        w_raddr    = r_idx;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_command;
                    n_value = i_value;
                    n_idx   = '0;
                    if (i_command == slir_pkg::CMD_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_valid  = 1'b1;
                            n_status = slir_pkg::ST_FULL;
                        end else if (r_count == '0) begin
                            n_pos   = '0;
                            n_state = S_PLACE;
                        end else begin
                            n_state = S_SRD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_valid  = 1'b1;
                            n_status = slir_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_SRD;
                        end
                    end
                end
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (r_cmd == slir_pkg::CMD_INSERT) begin
                    if (!w_lt) begin
                        // first entry not below the value: open a gap here
                        n_pos   = r_idx;
                        n_k     = AW'(r_count);
                        n_state = S_MRD;
                    end else if (w_last) begin
                        n_pos   = AW'(r_count);
                        n_state = S_PLACE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_SRD;
                    end
                end else begin
                    if (w_eq) begin
                        n_k = r_idx;
                        if ((CW'(r_idx) + CW'(1)) < r_count) begin
                            n_state = S_MRD;
                        end else begin
                            n_count  = r_count - CW'(1);
                            n_valid  = 1'b1;
                            n_status = slir_pkg::ST_OK;
                            n_state  = S_IDLE;
                        end
                    end else if (w_last) begin
                        n_valid  = 1'b1;
                        n_status = slir_pkg::ST_NOT_FOUND;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_SRD;
                    end
                end
            end
            S_MRD: begin
                w_raddr = (r_cmd == slir_pkg::CMD_INSERT) ? w_k_dec : w_k_inc;
                n_state = S_MWR;
            end
            S_MWR: begin
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = w_rdata;
                if (r_k == '0) begin
                    n_smallest = w_rdata;
                end
                if (r_cmd == slir_pkg::CMD_INSERT) begin
                    n_k = w_k_dec;
                    if (w_k_dec > r_pos) begin
                        n_state = S_MRD;
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_k = w_k_inc;
                    if (CW'(w_k_inc) < (r_count - CW'(1))) begin
                        n_state = S_MRD;
                    end else begin
                        n_count  = r_count - CW'(1);
                        n_valid  = 1'b1;
                        n_status = slir_pkg::ST_OK;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = r_value;
                if (r_pos == '0) begin
                    n_smallest = r_value;
                end
                n_count  = r_count + CW'(1);
                n_valid  = 1'b1;
                n_status = slir_pkg::ST_OK;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_value    <= n_value;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_smallest <= n_smallest;
        r_status   <= n_status;
    end

    // count only moves at the edge that raises the strobe; smallest also moves in a remove's shift
    assign w_count_ext      = {5'd0, r_count};
    assign busy             = r_state != S_IDLE;
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_count          = w_count_ext[4:0];
    assign o_smallest_valid = r_count != '0;
    assign o_smallest       = (r_count != '0) ? r_smallest : 32'sd0;

endmodule

// ===== rtl/slir_checker.sv =====
`include "assert_macros.svh"

module slir_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic [1:0]         o_status,
    input logic [4:0]         o_count,
    input logic signed [31:0] o_smallest,
    input logic               o_smallest_valid
);

    // a beat is never shown while a command is still at work
    `ASSERT_SAME(a_beat_idle, i_clk, i_rst_n, o_valid, !busy)

    // an accepted command either answers at once or keeps the unit busy
    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_valid)

    `ASSERT_SAME(a_full_nonempty, i_clk, i_rst_n,
        o_valid && (o_status == slir_pkg::ST_FULL), o_smallest_valid)

    `ASSERT_SAME(a_empty_zero, i_clk, i_rst_n,
        o_valid && (o_status == slir_pkg::ST_EMPTY), !o_smallest_valid && (o_count == 5'd0))

    `ASSERT_SAME(a_no_min_zero, i_clk, i_rst_n,
        o_valid && !o_smallest_valid, o_smallest == 32'sd0)

endmodule

bind sorted_list_insert_remove_unit slir_checker u_slir_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_count          (o_count),
    .o_smallest       (o_smallest),
    .o_smallest_valid (o_smallest_valid)
);

// ===== tb/sorted_list_checker.sv =====
`timescale 1ns / 1ps

// watches the command and result channels, keeps a shadow of the sorted store
// and compares every result beat with the oldest outstanding prediction
module sorted_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_command,
    input  logic signed [31:0] i_value,
    input  logic               i_valid,
    input  logic [1:0]         i_status,
    input  logic [4:0]         i_count,
    input  logic signed [31:0] i_smallest,
    input  logic               i_smallest_valid,
    output int                 o_pending,
    output int                 o_error_count
);

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         count;
        logic signed [31:0] smallest;
        logic               smallest_valid;
    } t_list_result;

    logic signed [31:0] shadow_entries [CAPACITY];
    int                 shadow_count;
    t_list_result       expected_results [$];
    int                 error_count;

    function automatic t_list_result apply_list_command(input logic cmd,
                                                        input logic signed [31:0] value);
        t_list_result res;
        int           pos;
        pos = 0;
        res.status = slir_pkg::ST_OK;
        if (cmd == slir_pkg::CMD_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                res.status = slir_pkg::ST_FULL;
            end else begin
                // lands ahead of any equal values
                while (pos < shadow_count && shadow_entries[pos] < value) pos++;
                for (int k = shadow_count; k > pos; k--)
                    shadow_entries[k] = shadow_entries[k - 1];
                shadow_entries[pos] = value;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = slir_pkg::ST_EMPTY;
            end else begin
                while (pos < shadow_count && shadow_entries[pos] != value) pos++;
                if (pos >= shadow_count) begin
                    res.status = slir_pkg::ST_NOT_FOUND;
                end else begin
                    for (int k = pos; k + 1 < shadow_count; k++)
                        shadow_entries[k] = shadow_entries[k + 1];
                    shadow_count--;
                end
            end
        end
        res.count = 5'(shadow_count);
        if (shadow_count > 0) begin
            res.smallest       = shadow_entries[0];
            res.smallest_valid = 1'b1;
        end else begin
            res.smallest       = '0;
            res.smallest_valid = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // result beat first, so a new command in the same cycle queues behind it
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        error_count++;
                    end
                    if (i_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, i_count);
                        error_count++;
                    end
                    if (i_smallest !== want.smallest) begin
                        $error("smallest: expected %0d, got %0d", want.smallest,
                               i_smallest);
                        error_count++;
                    end
                    if (i_smallest_valid !== want.smallest_valid) begin
                        $error("smallest_valid: expected %0d, got %0d",
                               want.smallest_valid, i_smallest_valid);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_list_command(i_command, i_value));
        end
        o_pending     <= expected_results.size();
        o_error_count <= error_count;
    end

endmodule

// ===== tb/tb_sorted_list_insert_remove_unit.sv =====
`timescale 1ns / 1ps

module tb_sorted_list_insert_remove_unit;

    localparam int CAPACITY     = 16;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 9;
    localparam int SETTLE_TIME  = 4 * CAPACITY + 16;
    localparam int CYCLE_LIMIT  = 600000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_command = slir_pkg::CMD_INSERT;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [4:0]         o_count;
    logic signed [31:0] o_smallest;
    logic               o_smallest_valid;
    int                 pending;
    int                 error_count;
    int                 cycles = 0;
    bit                 no_gaps = 1'b0;

    always #4 i_clk = ~i_clk;

    sorted_list_insert_remove_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_count          (o_count),
        .o_smallest       (o_smallest),
        .o_smallest_valid (o_smallest_valid)
    );

    sorted_list_checker #(
        .CAPACITY(CAPACITY)
    ) checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_value          (i_value),
        .i_valid          (o_valid),
        .i_status         (o_status),
        .i_count          (o_count),
        .i_smallest       (o_smallest),
        .i_smallest_valid (o_smallest_valid),
        .o_pending        (pending),
        .o_error_count    (error_count)
    );

    // mostly a narrow band so removes find their target and duplicates pile up
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom;
            2:       v = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
            3:       v = 32'($urandom_range(0, 7)) - 32'sd2147483648;
            default: v = $signed(32'($urandom_range(0, 12))) - 32'sd6;
        endcase
        return v;
    endfunction

    task automatic send_command(input logic cmd, input logic signed [31:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int insert_pct [NUM_PHASES];
        logic cmd;
        insert_pct = '{85, 50, 15, 70, 95, 10, 50, 30, 75};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, extremes, duplicates, absent value, fill, full
        send_command(slir_pkg::CMD_REMOVE, 32'sd0);
        send_command(slir_pkg::CMD_INSERT, 32'sh7fffffff);
        send_command(slir_pkg::CMD_INSERT, 32'sh80000000);
        send_command(slir_pkg::CMD_INSERT, 32'sd0);
        send_command(slir_pkg::CMD_INSERT, -32'sd1);
        send_command(slir_pkg::CMD_INSERT, 32'sd0);
        send_command(slir_pkg::CMD_REMOVE, 32'sd5);
        send_command(slir_pkg::CMD_REMOVE, 32'sd0);
        send_command(slir_pkg::CMD_REMOVE, 32'sh80000000);
        send_command(slir_pkg::CMD_REMOVE, 32'sh7fffffff);
        repeat (CAPACITY - 2) send_command(slir_pkg::CMD_INSERT, pick_value());
        send_command(slir_pkg::CMD_INSERT, 32'sd1);
        drain();

        // random phases sweep the fill level up and down
        for (int p = 0; p < NUM_PHASES; p++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = ($urandom_range(0, 99) < insert_pct[p]) ? slir_pkg::CMD_INSERT
                                                               : slir_pkg::CMD_REMOVE;
                send_command(cmd, pick_value());
            end
            if (p % 3 == 2) drain();
        end
        drain();
        repeat (SETTLE_TIME) @(posedge i_clk);

        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
